@@ design/gpf_pkg.sv @@
package gpf_pkg;

   // Default store depths.
   localparam int ADDR_ENTRIES_DEF   = 1024;
   localparam int POLICY_ENTRIES_DEF = 1024;

   // Register reset values and indexes.
   localparam logic [31:0] SUBNET_VALUE_RST = 32'h0a01_0000;
   localparam logic [31:0] SUBNET_MASK_RST  = 32'hffff_0000;
   localparam logic        CSR_SUBNET_VALUE = 1'b0;
   localparam logic        CSR_SUBNET_MASK  = 1'b1;

   // Item kinds.
   localparam logic [2:0] FUNC_INGRESS  = 3'd0;
   localparam logic [2:0] FUNC_EGRESS   = 3'd1;
   localparam logic [2:0] FUNC_SET_ADDR = 3'd2;
   localparam logic [2:0] FUNC_SET_POL  = 3'd3;
   localparam logic [2:0] FUNC_READ_POL = 3'd4;

   // Ethertypes.
   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_IPV6 = 16'h86dd;
   localparam logic [15:0] ETH_ARP  = 16'h0806;

   // Result status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_UNKNOWN  = 3'd1;
   localparam logic [2:0] ST_ARP      = 3'd2;
   localparam logic [2:0] ST_UNMAPPED = 3'd3;
   localparam logic [2:0] ST_NOPOLICY = 3'd4;
   localparam logic [2:0] ST_OUTSIDE  = 3'd5;
   localparam logic [2:0] ST_FULL     = 3'd6;

   // Policy action that lets a packet through, and the tap action (drops).
   localparam logic [1:0] ACT_PASS = 2'd1;
   localparam logic [1:0] ACT_TAP  = 2'd2;

   typedef struct packed {
      logic [31:0] key;
      logic [15:0] group;
   } addr_entry_type;

   typedef struct packed {
      logic [31:0] key;
      logic [1:0]  action;
      logic [63:0] packets;
      logic [63:0] bytes;
   } pol_entry_type;

endpackage

@@ design/gpf_ram.sv @@
module gpf_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 16)
   (input  logic                     clock,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/group_policy_packet_filter.sv @@
// Group-based policy filter. Each beat on req_ gives exactly one beat on
// rsp_. Both exact-match stores fill from entry zero upward and are never
// shrunk, so a fill count marks the valid entries and no clearing pass is
// needed after reset. A lookup scans the filled entries one per cycle
// through the store's single read port. An item is classified, scans
// none, one or both stores as its kind needs, and then waits in a
// finish state until the output register is free. A new beat is taken
// as soon as the engine is idle, even while a result still waits on rsp_.
module group_policy_packet_filter
   import gpf_pkg::*;
   #(parameter int ADDR_ENTRIES   = ADDR_ENTRIES_DEF,
     parameter int POLICY_ENTRIES = POLICY_ENTRIES_DEF)
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  req_func,
    input  logic [15:0] req_ethertype,
    input  logic [31:0] req_src_addr,
    input  logic [31:0] req_dst_addr,
    input  logic [15:0] req_in_tag,
    input  logic [15:0] req_pkt_len,
    input  logic [31:0] req_map_addr,
    input  logic [15:0] req_map_group,
    input  logic [15:0] req_pol_src_group,
    input  logic [15:0] req_pol_dst_group,
    input  logic [1:0]  req_pol_action,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic        rsp_verdict,
    output logic [15:0] rsp_out_tag,
    output logic        rsp_tag_written,
    output logic [2:0]  rsp_status,
    output logic [63:0] rsp_pkt_count,
    output logic [63:0] rsp_byte_count,
    input  logic        csr_we,
    input  logic        csr_index,
    input  logic [31:0] csr_wdata);

   localparam int AW = $clog2(ADDR_ENTRIES);
   localparam int PW = $clog2(POLICY_ENTRIES);
   localparam int AE_W = $bits(addr_entry_type);
   localparam int PE_W = $bits(pol_entry_type);
   localparam logic [AW:0] ADDR_FULL = (AW+1)'(ADDR_ENTRIES);
   localparam logic [PW:0] POL_FULL  = (PW+1)'(POLICY_ENTRIES);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ASCAN = 2'd1;
   localparam logic [1:0] S_PSCAN = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] subnet_value_ff, subnet_mask_ff;
   logic [2:0]  func_ff, func_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] pkey_ff, pkey_in;
   logic [15:0] tag_ff, tag_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] group_ff, group_in;
   logic [1:0]  action_ff, action_in;
   logic [AW:0] aidx_ff, aidx_in, acount_ff, acount_in;
   logic [PW:0] pidx_ff, pidx_in, pcount_ff, pcount_in;
   logic        pend_ff, pend_in;

   logic        res_verdict_ff, res_verdict_in;
   logic [15:0] res_tag_ff, res_tag_in;
   logic        res_written_ff, res_written_in;
   logic [2:0]  res_status_ff, res_status_in;
   logic [63:0] res_pkts_ff, res_pkts_in;
   logic [63:0] res_bytes_ff, res_bytes_in;

   logic        rsp_valid_ff;
   logic        rsp_verdict_ff, rsp_written_ff;
   logic [15:0] rsp_tag_ff;
   logic [2:0]  rsp_status_ff;
   logic [63:0] rsp_pkts_ff, rsp_bytes_ff;

   logic           a_we, p_we;
   logic [AW-1:0]  a_waddr, a_raddr, a_hit_idx;
   logic [PW-1:0]  p_waddr, p_raddr, p_hit_idx;
   addr_entry_type a_wdata, a_rdata;
   pol_entry_type  p_wdata, p_rdata;
   logic [AE_W-1:0] a_rdata_raw;
   logic [PE_W-1:0] p_rdata_raw;
   logic           a_hit, p_hit, load_rsp;
   logic           is_ipv4, is_ipv6;
   logic [63:0]    new_pkts, new_bytes;

   gpf_ram #(.WIDTH(AE_W), .DEPTH(ADDR_ENTRIES)) u_addr_ram (
      .clock(clock), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
      .raddr(a_raddr), .rdata(a_rdata_raw));

   gpf_ram #(.WIDTH(PE_W), .DEPTH(POLICY_ENTRIES)) u_pol_ram (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .raddr(p_raddr), .rdata(p_rdata_raw));

   assign a_rdata = addr_entry_type'(a_rdata_raw);
   assign p_rdata = pol_entry_type'(p_rdata_raw);

   // The entry read last cycle sits one below the scan index.
   assign a_hit_idx = AW'(aidx_ff - 1'b1);
   assign p_hit_idx = PW'(pidx_ff - 1'b1);
   assign a_hit     = pend_ff && (a_rdata.key == key_ff);
   assign p_hit     = pend_ff && (p_rdata.key == pkey_ff);
   assign a_raddr   = aidx_ff[AW-1:0];
   assign p_raddr   = pidx_ff[PW-1:0];
   assign new_pkts  = p_rdata.packets + 64'd1;
   assign new_bytes = p_rdata.bytes + {48'd0, len_ff};

   assign is_ipv4   = (req_ethertype == ETH_IPV4);
   assign is_ipv6   = (req_ethertype == ETH_IPV6);
   assign req_ready = (state_ff == S_IDLE);
   assign load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer: classify, scan the address store, scan the policy store.
   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      key_in         = key_ff;
      pkey_in        = pkey_ff;
      tag_in         = tag_ff;
      len_in         = len_ff;
      group_in       = group_ff;
      action_in      = action_ff;
      aidx_in        = aidx_ff;
      pidx_in        = pidx_ff;
      acount_in      = acount_ff;
      pcount_in      = pcount_ff;
      pend_in        = 1'b0;
      res_verdict_in = res_verdict_ff;
      res_tag_in     = res_tag_ff;
      res_written_in = res_written_ff;
      res_status_in  = res_status_ff;
      res_pkts_in    = res_pkts_ff;
      res_bytes_in   = res_bytes_ff;
      a_we           = 1'b0;
      a_waddr        = a_hit_idx;
      a_wdata        = '{key: key_ff, group: group_ff};
      p_we           = 1'b0;
      p_waddr        = p_hit_idx;
      p_wdata        = '{key: pkey_ff, action: action_ff, packets: 64'd0, bytes: 64'd0};
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in        = req_func;
               tag_in         = req_in_tag;
               len_in         = req_pkt_len;
               group_in       = req_map_group;
               action_in      = req_pol_action;
               pkey_in        = {req_pol_src_group, req_pol_dst_group};
               aidx_in        = '0;
               pidx_in        = '0;
               res_verdict_in = 1'b0;
               res_tag_in     = '0;
               res_written_in = 1'b0;
               res_status_in  = ST_OK;
               res_pkts_in    = '0;
               res_bytes_in   = '0;
               state_in       = S_DONE;
               case (req_func)
                  FUNC_INGRESS, FUNC_EGRESS: begin
                     if (req_ethertype == ETH_ARP) begin
                        res_status_in = ST_ARP;
                     end else if (!is_ipv4 && !is_ipv6) begin
                        res_status_in  = ST_UNKNOWN;
                        res_verdict_in = 1'b1;
                     end else if (req_func == FUNC_INGRESS) begin
                        key_in   = is_ipv4 ? req_dst_addr : '0;
                        state_in = S_ASCAN;
                     end else if (is_ipv4 && ((req_dst_addr & subnet_mask_ff)
                                              != subnet_value_ff)) begin
                        res_status_in = ST_OUTSIDE;
                     end else begin
                        key_in   = is_ipv4 ? req_src_addr : '0;
                        state_in = S_ASCAN;
                     end
                  end
                  FUNC_SET_ADDR: begin
                     key_in   = req_map_addr;
                     state_in = S_ASCAN;
                  end
                  FUNC_SET_POL, FUNC_READ_POL: begin
                     state_in = S_PSCAN;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ASCAN: begin
            if (a_hit) begin
               case (func_ff)
                  FUNC_INGRESS: begin
                     pkey_in  = {tag_ff, a_rdata.group};
                     state_in = S_PSCAN;
                  end
                  FUNC_EGRESS: begin
                     res_tag_in     = a_rdata.group;
                     res_written_in = 1'b1;
                     state_in       = S_DONE;
                  end
                  default: begin
                     // Existing key: overwrite in place.
                     a_we     = 1'b1;
                     state_in = S_DONE;
                  end
               endcase
            end else if (aidx_ff < acount_ff) begin
               aidx_in = aidx_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               state_in = S_DONE;
               case (func_ff)
                  FUNC_INGRESS: begin
                     res_status_in  = ST_UNMAPPED;
                     res_verdict_in = 1'b1;
                  end
                  FUNC_EGRESS: begin
                     res_status_in = ST_UNMAPPED;
                  end
                  default: begin
                     if (acount_ff == ADDR_FULL) begin
                        res_status_in = ST_FULL;
                     end else begin
                        a_we      = 1'b1;
                        a_waddr   = acount_ff[AW-1:0];
                        acount_in = acount_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         S_PSCAN: begin
            if (p_hit) begin
               state_in = S_DONE;
               case (func_ff)
                  FUNC_INGRESS: begin
                     p_we           = 1'b1;
                     p_wdata        = '{key: p_rdata.key, action: p_rdata.action,
                                        packets: new_pkts, bytes: new_bytes};
                     res_pkts_in    = new_pkts;
                     res_bytes_in   = new_bytes;
                     res_verdict_in = (p_rdata.action != ACT_PASS);
                  end
                  FUNC_SET_POL: begin
                     p_we = 1'b1;
                  end
                  default: begin
                     res_pkts_in  = p_rdata.packets;
                     res_bytes_in = p_rdata.bytes;
                  end
               endcase
            end else if (pidx_ff < pcount_ff) begin
               pidx_in = pidx_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               state_in = S_DONE;
               case (func_ff)
                  FUNC_INGRESS: begin
                     res_status_in  = ST_NOPOLICY;
                     res_verdict_in = 1'b1;
                  end
                  FUNC_SET_POL: begin
                     if (pcount_ff == POL_FULL) begin
                        res_status_in = ST_FULL;
                     end else begin
                        p_we      = 1'b1;
                        p_waddr   = pcount_ff[PW-1:0];
                        pcount_in = pcount_ff + 1'b1;
                     end
                  end
                  default: begin
                     res_status_in = ST_NOPOLICY;
                  end
               endcase
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         acount_ff       <= '0;
         pcount_ff       <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         subnet_value_ff <= SUBNET_VALUE_RST;
         subnet_mask_ff  <= SUBNET_MASK_RST;
      end else begin
         state_ff  <= state_in;
         acount_ff <= acount_in;
         pcount_ff <= pcount_in;
         pend_ff   <= pend_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            if (csr_index == CSR_SUBNET_VALUE) begin
               subnet_value_ff <= csr_wdata;
            end else if (csr_index == CSR_SUBNET_MASK) begin
               subnet_mask_ff <= csr_wdata;
            end
         end
      end
   end

   // Item payload, staged result and output beat.
   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      key_ff         <= key_in;
      pkey_ff        <= pkey_in;
      tag_ff         <= tag_in;
      len_ff         <= len_in;
      group_ff       <= group_in;
      action_ff      <= action_in;
      aidx_ff        <= aidx_in;
      pidx_ff        <= pidx_in;
      res_verdict_ff <= res_verdict_in;
      res_tag_ff     <= res_tag_in;
      res_written_ff <= res_written_in;
      res_status_ff  <= res_status_in;
      res_pkts_ff    <= res_pkts_in;
      res_bytes_ff   <= res_bytes_in;
      if (load_rsp) begin
         rsp_verdict_ff <= res_verdict_ff;
         rsp_tag_ff     <= res_tag_ff;
         rsp_written_ff <= res_written_ff;
         rsp_status_ff  <= res_status_ff;
         rsp_pkts_ff    <= res_pkts_ff;
         rsp_bytes_ff   <= res_bytes_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_out_tag     = rsp_tag_ff;
   assign rsp_tag_written = rsp_written_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pkt_count   = rsp_pkts_ff;
   assign rsp_byte_count  = rsp_bytes_ff;

   // The fill counts never pass the store depth.
   assert property (@(posedge clock) disable iff (reset)
      (acount_ff <= ADDR_FULL) && (pcount_ff <= POL_FULL))
      else $error("store fill count beyond depth");

   // Store writes land inside the filled region or just past it.
   assert property (@(posedge clock) disable iff (reset)
      a_we |-> ({1'b0, a_waddr} <= acount_ff))
      else $error("address store write outside filled region");

   assert property (@(posedge clock) disable iff (reset)
      p_we |-> ({1'b0, p_waddr} <= pcount_ff))
      else $error("policy store write outside filled region");

   // A new result beat only comes out of the finish state.
   assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("result beat not presented after finish");

endmodule
